[sv/scc_pkg.sv]
package scc_pkg;

  // key size and derived widths
  localparam int KEY_ENTRIES = 62;
  localparam int KEY_IDX_W   = $clog2(KEY_ENTRIES);
  localparam int LD_CNT_W    = $clog2(KEY_ENTRIES + 1);

  // running count width, reported on a 16-bit field
  localparam int COUNT_BITS  = 16;
  localparam int RUN_W       = 16;

  // item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_LOAD   = 2'd1;
  localparam logic [1:0] KIND_ENCODE = 2'd2;
  localparam logic [1:0] KIND_DECODE = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_DUPLICATE  = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;
  localparam logic [1:0] ST_OVERFLOW   = 2'd3;

  typedef struct packed {
    logic                 hit;
    logic [KEY_IDX_W-1:0] pos;
  } alpha_pos_t;

  // alphabet order a-z, A-Z, 1-9, 0
  function automatic alpha_pos_t alpha_pos(input logic [7:0] b);
    alpha_pos_t r;
    r.hit = 1'b1;
    r.pos = '0;
    case (b) inside
      [8'h61:8'h7a]: r.pos = KEY_IDX_W'(b - 8'h61);
      [8'h41:8'h5a]: r.pos = KEY_IDX_W'(b - 8'h41 + 8'd26);
      [8'h31:8'h39]: r.pos = KEY_IDX_W'(b - 8'h31 + 8'd52);
      8'h30:         r.pos = KEY_IDX_W'(61);
      default:       r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] alpha_char(input logic [KEY_IDX_W-1:0] pos);
    logic [7:0] p;
    logic [7:0] c;
    p = 8'(pos);
    case (p) inside
      [8'd0:8'd25]:  c = 8'h61 + p;
      [8'd26:8'd51]: c = 8'h41 + (p - 8'd26);
      [8'd52:8'd60]: c = 8'h31 + (p - 8'd52);
      default:       c = 8'h30;
    endcase
    return c;
  endfunction

endpackage

[sv/substitution_cipher_codec.sv]
// channel  | direction | handshake             | word
// ---------+-----------+-----------------------+----------------------------------------
// in_      | input     | in_valid / in_ready   | in_kind, in_byte, in_last_char
// out_     | output    | out_valid / out_ready | out_byte, out_substituted, out_run_total,
//          |           |                       | out_status, out_text_end
//
// one word per cycle sustained while out_ready is high; a result is offered once its word has passed
// the read stage (table reads captured with the word) and then the result register
// rst_n (synchronous) empties both stages, the key fill count, the duplicate flag,
// the running count and the inverse valid bits; a clear word empties the valid bits at once
// a stall on out_ready holds the result register, then the read stage, then in_ready
// while the read stage is empty a waiting result does not block the next word
module substitution_cipher_codec (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_kind,
  input  logic [7:0] in_byte,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_substituted,
  output logic [15:0] out_run_total,
  output logic [1:0] out_status,
  output logic       out_text_end
);

  localparam int KIW = scc_pkg::KEY_IDX_W;
  localparam int LDW = scc_pkg::LD_CNT_W;
  localparam int CW  = scc_pkg::COUNT_BITS;

  // key and inverse storage; inverse holds alphabet position, validity in flops
  logic [7:0]     key_mem [scc_pkg::KEY_ENTRIES];
  logic [KIW-1:0] inv_mem [256];
  logic [255:0]   inv_valid_r;

  // read stage
  logic           s1_v_r;
  logic [1:0]     s1_kind_r;
  logic [7:0]     s1_byte_r;
  logic           s1_last_r;
  logic [7:0]     key_rd_r;
  logic [KIW-1:0] inv_rd_r;

  // block state
  logic [LDW-1:0] loaded_r, loaded_nxt;
  logic           dup_r, dup_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  // result register
  logic           out_v_r;
  logic [7:0]     obyte_r;
  logic           subst_r;
  logic [15:0]    run_r;
  logic [1:0]     status_r;
  logic           tend_r;

  logic           in_acc, s1_adv;
  scc_pkg::alpha_pos_t rd_ap, s1_ap;
  logic           vbit;
  logic           key_we, inv_we, clr;
  logic [KIW-1:0] key_wa;
  logic [7:0]     obyte;
  logic           subst;
  logic [1:0]     status;
  logic [CW-1:0]  count_upd;
  logic [31:0]    count_wide;
  logic [15:0]    run_rep;

  // handshake: read stage moves when the result register is free or being taken
  assign s1_adv   = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  assign rd_ap = scc_pkg::alpha_pos(in_byte);
  assign s1_ap = scc_pkg::alpha_pos(s1_byte_r);
  assign vbit  = inv_valid_r[s1_byte_r];
  assign key_wa = KIW'(loaded_r);

  // result logic and next state for the word in the read stage
  always_comb begin
    obyte      = 8'd0;
    subst      = 1'b0;
    status     = scc_pkg::ST_OK;
    loaded_nxt = loaded_r;
    dup_nxt    = dup_r;
    key_we     = 1'b0;
    inv_we     = 1'b0;
    clr        = 1'b0;
    case (s1_kind_r)
      scc_pkg::KIND_CLEAR: begin
        loaded_nxt = '0;
        dup_nxt    = 1'b0;
        clr        = 1'b1;
      end
      scc_pkg::KIND_LOAD: begin
        if (loaded_r >= LDW'(scc_pkg::KEY_ENTRIES)) begin
          status = scc_pkg::ST_OVERFLOW;
        end else begin
          key_we = 1'b1;
          // a repeated character is kept in the key but the inverse keeps its first spot
          if (vbit) begin
            dup_nxt = 1'b1;
            status  = scc_pkg::ST_DUPLICATE;
          end else begin
            inv_we = 1'b1;
          end
          loaded_nxt = loaded_r + LDW'(1);
        end
      end
      default: begin
        if (dup_r) begin
          status = scc_pkg::ST_DUPLICATE;
        end else if (loaded_r < LDW'(scc_pkg::KEY_ENTRIES)) begin
          status = scc_pkg::ST_INCOMPLETE;
        end else begin
          obyte = s1_byte_r;
          if (s1_kind_r == scc_pkg::KIND_ENCODE) begin
            if (s1_ap.hit) begin
              obyte = key_rd_r;
              subst = 1'b1;
            end
          end else if (vbit) begin
            obyte = scc_pkg::alpha_char(inv_rd_r);
            subst = 1'b1;
          end
        end
      end
    endcase

    // saturating count, reported clipped to 16 bits, restarted after a last word
    count_upd = count_r;
    if (subst && (count_r != {CW{1'b1}})) begin
      count_upd = count_r + CW'(1);
    end
    count_wide = 32'(count_upd);
    run_rep    = (count_wide > 32'h0000_FFFF) ? 16'hFFFF : count_wide[15:0];
    count_nxt  = s1_last_r ? '0 : count_upd;
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (s1_adv && key_we) begin
      key_mem[key_wa] <= s1_byte_r;
    end
    if (s1_adv && inv_we) begin
      inv_mem[s1_byte_r] <= KIW'(loaded_r);
    end
  end

  // memory reads, with the write of the same edge forwarded
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (s1_adv && key_we && (key_wa == rd_ap.pos)) begin
        key_rd_r <= s1_byte_r;
      end else begin
        key_rd_r <= key_mem[rd_ap.pos];
      end
      if (s1_adv && inv_we && (s1_byte_r == in_byte)) begin
        inv_rd_r <= KIW'(loaded_r);
      end else begin
        inv_rd_r <= inv_mem[in_byte];
      end
    end
  end

  // inverse valid bits, emptied at once by a clear word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_valid_r <= '0;
    end else if (s1_adv && clr) begin
      inv_valid_r <= '0;
    end else if (s1_adv && inv_we) begin
      inv_valid_r[s1_byte_r] <= 1'b1;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_byte;
      s1_last_r <= in_last_char;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      obyte_r  <= obyte;
      subst_r  <= subst;
      run_r    <= run_rep;
      status_r <= status;
      tend_r   <= s1_last_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      loaded_r <= '0;
      dup_r    <= 1'b0;
      count_r  <= '0;
    end else begin
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (s1_adv) begin
        loaded_r <= loaded_nxt;
        dup_r    <= dup_nxt;
        count_r  <= count_nxt;
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_byte        = obyte_r;
  assign out_substituted = subst_r;
  assign out_run_total   = run_r;
  assign out_status      = status_r;
  assign out_text_end    = tend_r;

  // key fill never passes the key size
  a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= LDW'(scc_pkg::KEY_ENTRIES))
    else $error("key fill count beyond key size");

  // a substituted byte always comes with ok status
  a_subst_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_substituted) |-> (out_status == scc_pkg::ST_OK))
    else $error("substituted byte with error status");

  // the read stage never overwrites a result still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_adv && out_v_r && !out_ready))
    else $error("result register overrun");

  // count restarts after a last word
  a_count_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (count_r == '0))
    else $error("running count not restarted after last word");

endmodule

[sim/substitution_cipher_codec_test.sv]
module substitution_cipher_codec_test;

  // plain alphabet in key order, first character in the top byte
  localparam logic [8*scc_pkg::KEY_ENTRIES-1:0] LETTERS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ1234567890";
  // long text sent with no idling on the sender
  localparam int LONG_RUN = 250;
  localparam int RANDOM_WORDS = 1250;

  // one word on the input channel, with the idle time before it
  typedef struct {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    int         gap;
    bit         drain;
  } text_word_t;

  // one word on the result channel
  typedef struct {
    logic [7:0]                ch;
    logic                      subst;
    logic [scc_pkg::RUN_W-1:0] total;
    logic [1:0]                status;
    logic                      last;
  } codec_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_kind = scc_pkg::KIND_CLEAR;
  logic [7:0] in_byte = 8'h00;
  logic       in_last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_substituted;
  logic [15:0] out_run_total;
  logic [1:0] out_status;
  logic       out_text_end;

  substitution_cipher_codec i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_byte         (in_byte),
    .in_last_char    (in_last_char),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_substituted (out_substituted),
    .out_run_total   (out_run_total),
    .out_status      (out_status),
    .out_text_end    (out_text_end)
  );

  // period of two time units
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  text_word_t    word_queue [$];
  codec_result_t result_queue [$];
  int            err_count = 0;
  int            checked_count = 0;

  // codec state as the predictor sees it
  logic [7:0]                     key_tab [scc_pkg::KEY_ENTRIES];
  logic [6:0]                     inv_tab [256];
  int unsigned                    key_fill;
  bit                             dup_flag;
  logic [scc_pkg::COUNT_BITS-1:0] run_cnt;

  // stimulus build state
  bit         gen_calm = 1'b0;
  bit         next_drain = 1'b0;
  logic [7:0] plan_key [scc_pkg::KEY_ENTRIES];

  function automatic logic [7:0] letter_at(input int pos);
    return LETTERS[8*(scc_pkg::KEY_ENTRIES-1-pos) +: 8];
  endfunction

  // position in the plain alphabet, -1 for any other byte
  function automatic int letter_index(input logic [7:0] b);
    for (int i = 0; i < scc_pkg::KEY_ENTRIES; i++)
      if (letter_at(i) == b) return i;
    return -1;
  endfunction

  task automatic clear_codec_state();
    for (int i = 0; i < 256; i++) inv_tab[i] = 7'd0;
    for (int i = 0; i < scc_pkg::KEY_ENTRIES; i++) key_tab[i] = 8'h00;
    key_fill = 0;
    dup_flag = 1'b0;
    run_cnt  = '0;
  endtask

  // next result of the codec for one accepted word, updating the state
  function automatic codec_result_t codec_step(input logic [1:0] kind, input logic [7:0] b,
                                               input logic last);
    codec_result_t r;
    int            p;
    logic [6:0]    v;
    r.ch     = 8'h00;
    r.subst  = 1'b0;
    r.status = scc_pkg::ST_OK;
    r.last   = last;
    case (kind)
      scc_pkg::KIND_CLEAR: begin
        // running count survives a clear
        for (int i = 0; i < 256; i++) inv_tab[i] = 7'd0;
        key_fill = 0;
        dup_flag = 1'b0;
      end
      scc_pkg::KIND_LOAD: begin
        if (key_fill >= scc_pkg::KEY_ENTRIES) begin
          r.status = scc_pkg::ST_OVERFLOW;
        end else begin
          key_tab[key_fill] = b;
          // a repeated character keeps its first inverse position
          if (inv_tab[b] != 7'd0) begin
            dup_flag = 1'b1;
            r.status = scc_pkg::ST_DUPLICATE;
          end else begin
            inv_tab[b] = 7'(key_fill + 1);
          end
          key_fill++;
        end
      end
      default: begin
        if (dup_flag) begin
          r.status = scc_pkg::ST_DUPLICATE;
        end else if (key_fill < scc_pkg::KEY_ENTRIES) begin
          r.status = scc_pkg::ST_INCOMPLETE;
        end else begin
          r.ch = b;
          if (kind == scc_pkg::KIND_ENCODE) begin
            p = letter_index(b);
            if (p >= 0) begin
              r.ch    = key_tab[p];
              r.subst = 1'b1;
            end
          end else begin
            v = inv_tab[b];
            if (v >= 7'd1 && v <= scc_pkg::KEY_ENTRIES) begin
              r.ch    = letter_at(int'(v) - 1);
              r.subst = 1'b1;
            end
          end
          if (r.subst && run_cnt != '1) run_cnt++;
        end
      end
    endcase
    if (scc_pkg::COUNT_BITS > scc_pkg::RUN_W && run_cnt > {scc_pkg::RUN_W{1'b1}})
      r.total = '1;
    else
      r.total = scc_pkg::RUN_W'(run_cnt);
    if (last) run_cnt = '0;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch in %s at result %0d: got %0h, expected %0h",
             what, checked_count, got, want);
    err_count++;
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic push_word(input logic [1:0] kind, input logic [7:0] data, input logic last);
    text_word_t w;
    w.kind  = kind;
    w.data  = data;
    w.last  = last;
    w.gap   = gen_calm ? 0 : pick_gap();
    w.drain = next_drain;
    next_drain = 1'b0;
    word_queue.push_back(w);
  endtask

  task automatic load_plan_key();
    for (int i = 0; i < scc_pkg::KEY_ENTRIES; i++)
      push_word(scc_pkg::KIND_LOAD, plan_key[i], 1'b0);
  endtask

  // either a shuffle of the alphabet or any 62 distinct bytes
  task automatic make_random_key();
    int pool [256];
    int j;
    int t;
    int n;
    n = ($urandom_range(0, 1) == 0) ? scc_pkg::KEY_ENTRIES : 256;
    for (int i = 0; i < n; i++) pool[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = pool[i];
      pool[i] = pool[j];
      pool[j] = t;
    end
    for (int i = 0; i < scc_pkg::KEY_ENTRIES; i++)
      plan_key[i] = (n == scc_pkg::KEY_ENTRIES) ? letter_at(pool[i]) : 8'(pool[i]);
  endtask

  // a text of mixed encode and decode words, mostly bytes that substitute
  task automatic push_text(input int len);
    logic [1:0] kind;
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      kind = ($urandom_range(0, 1) == 0) ? scc_pkg::KIND_ENCODE : scc_pkg::KIND_DECODE;
      if ($urandom_range(0, 99) < 20)
        b = 8'($urandom_range(0, 255));
      else if (kind == scc_pkg::KIND_ENCODE)
        b = letter_at($urandom_range(0, scc_pkg::KEY_ENTRIES - 1));
      else
        b = plan_key[$urandom_range(0, scc_pkg::KEY_ENTRIES - 1)];
      push_word(kind, b, i == len - 1);
    end
  endtask

  // ---------------------------------------------------------------
  // driver: presents queued words at the falling edge
  // ---------------------------------------------------------------
  text_word_t cur_word;
  bit         staged = 1'b0;
  int         gap_left = 0;
  logic       in_taken = 1'b0;

  always @(negedge clk) begin : drive_words
    logic nv;
    // a word not yet taken stays on the bus untouched
    nv = in_valid && !in_taken;
    if (rst_n && !nv) begin
      if (!staged && word_queue.size() != 0) begin
        cur_word = word_queue.pop_front();
        staged   = 1'b1;
        gap_left = cur_word.gap;
      end
      if (staged) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(cur_word.drain && result_queue.size() != 0)) begin
          // a drain word holds off until every result is back
          nv           = 1'b1;
          staged       = 1'b0;
          in_kind      <= cur_word.kind;
          in_byte      <= cur_word.data;
          in_last_char <= cur_word.last;
        end
      end
    end
    in_valid <= nv;
  end

  // ---------------------------------------------------------------
  // receiver: random back-pressure, with recurring calm windows of unstalled cycles
  // ---------------------------------------------------------------
  int stall_left = 0;
  int rx_cycle = 0;

  always @(negedge clk) begin
    rx_cycle++;
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = (rx_cycle % 1024 < 200) ? 0 : pick_gap();
    end
  end

  // ---------------------------------------------------------------
  // monitor and predictor: both sampled at the rising edge
  // ---------------------------------------------------------------
  always @(posedge clk) begin : check_results
    codec_result_t want;
    if (!rst_n) begin
      clear_codec_state();
      in_taken <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          $display("result word %0h with nothing pending", out_byte);
          err_count++;
        end else begin
          want = result_queue.pop_front();
          if (out_byte !== want.ch) report_mismatch("out_byte", out_byte, want.ch);
          if (out_substituted !== want.subst)
            report_mismatch("out_substituted", out_substituted, want.subst);
          if (out_run_total !== want.total)
            report_mismatch("out_run_total", out_run_total, want.total);
          if (out_status !== want.status) report_mismatch("out_status", out_status, want.status);
          if (out_text_end !== want.last) report_mismatch("out_text_end", out_text_end, want.last);
        end
        checked_count++;
      end
      if (in_valid && in_ready)
        result_queue.push_back(codec_step(in_kind, in_byte, in_last_char));
      in_taken <= in_valid && in_ready;
    end
  end

  // ---------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------
  initial begin
    int base;
    int r;
    int n;

    // no key after reset: both text kinds report an incomplete key
    push_word(scc_pkg::KIND_ENCODE, "a", 1'b0);
    push_word(scc_pkg::KIND_DECODE, 8'hFF, 1'b1);
    push_word(scc_pkg::KIND_CLEAR, 8'h00, 1'b0);
    // key with the byte extremes in the first two slots, the rest reversed
    plan_key[0] = 8'hFF;
    plan_key[1] = 8'h00;
    for (int i = 2; i < scc_pkg::KEY_ENTRIES; i++)
      plan_key[i] = letter_at(scc_pkg::KEY_ENTRIES - 1 - i);
    load_plan_key();
    // one load past a full key
    push_word(scc_pkg::KIND_LOAD, 8'h80, 1'b0);
    // alphabet range ends, non-alphabet extremes passing through on encode, then decodes
    push_word(scc_pkg::KIND_ENCODE, "a", 1'b0);
    push_word(scc_pkg::KIND_ENCODE, "z", 1'b0);
    push_word(scc_pkg::KIND_ENCODE, "A", 1'b0);
    push_word(scc_pkg::KIND_ENCODE, "Z", 1'b0);
    push_word(scc_pkg::KIND_ENCODE, "1", 1'b0);
    push_word(scc_pkg::KIND_ENCODE, "9", 1'b0);
    push_word(scc_pkg::KIND_ENCODE, "0", 1'b0);
    push_word(scc_pkg::KIND_ENCODE, 8'h00, 1'b0);
    push_word(scc_pkg::KIND_ENCODE, 8'hFF, 1'b1);
    push_word(scc_pkg::KIND_DECODE, 8'hFF, 1'b0);
    push_word(scc_pkg::KIND_DECODE, 8'h00, 1'b0);
    push_word(scc_pkg::KIND_DECODE, "a", 1'b0);
    push_word(scc_pkg::KIND_DECODE, 8'h7F, 1'b1);
    // clear carrying a last mark, then a repeated key character
    push_word(scc_pkg::KIND_CLEAR, 8'h00, 1'b1);
    push_word(scc_pkg::KIND_LOAD, "q", 1'b0);
    push_word(scc_pkg::KIND_LOAD, "q", 1'b0);
    // duplicate wins over the incomplete key
    push_word(scc_pkg::KIND_ENCODE, "q", 1'b0);
    push_word(scc_pkg::KIND_DECODE, "q", 1'b1);
    push_word(scc_pkg::KIND_CLEAR, 8'h00, 1'b0);

    // random part: mostly full keys with texts, some broken keys and noise
    base = word_queue.size();
    next_drain = 1'b1;
    while (word_queue.size() < base + RANDOM_WORDS) begin
      gen_calm = ($urandom_range(0, 99) < 20);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        push_word(scc_pkg::KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        make_random_key();
        load_plan_key();
        if ($urandom_range(0, 99) < 5)
          push_word(scc_pkg::KIND_LOAD, 8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 99) < 10) next_drain = 1'b1;
        n = $urandom_range(1, 4);
        for (int t = 0; t < n; t++) push_text($urandom_range(1, 30));
      end else if (r < 85) begin
        push_word(scc_pkg::KIND_CLEAR, 8'h00, 1'b0);
        n = $urandom_range(0, 70);
        for (int i = 0; i < n; i++)
          push_word(scc_pkg::KIND_LOAD,
                    ($urandom_range(0, 1) == 0) ? letter_at($urandom_range(0, 7))
                                                : 8'($urandom_range(0, 255)), 1'b0);
        for (int i = 0; i < 3; i++)
          push_word(($urandom_range(0, 1) == 0) ? scc_pkg::KIND_ENCODE : scc_pkg::KIND_DECODE,
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        for (int i = 0; i < 10; i++)
          push_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
      end
    end

    // one long text without idling on the sender
    gen_calm = 1'b1;
    push_word(scc_pkg::KIND_CLEAR, 8'h00, 1'b1);
    make_random_key();
    load_plan_key();
    for (int i = 0; i < LONG_RUN; i++)
      push_word(scc_pkg::KIND_ENCODE, letter_at($urandom_range(0, scc_pkg::KEY_ENTRIES - 1)),
                1'b0);
    push_word(scc_pkg::KIND_ENCODE, "a", 1'b1);
    // count restarts after the last mark
    push_word(scc_pkg::KIND_ENCODE, "b", 1'b0);
    push_word(scc_pkg::KIND_DECODE, plan_key[3], 1'b1);
    gen_calm = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (word_queue.size() != 0 || staged || in_valid) @(posedge clk);
    while (result_queue.size() != 0) @(posedge clk);
    // then wait on to catch any stray result
    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
